// File: rtl/orl_pkg.sv
// Package for the object record loader: parse phases, sizes, result struct
// and character helpers. No dependencies.
package orl_pkg;

  localparam int ADDRESS_BITS = 16;
  localparam int NAME_LENGTH  = 6;
  localparam int BIT_SEL_BITS = 4;                        // 16 bitmap bits per row
  localparam int ROW_BITS     = ADDRESS_BITS - BIT_SEL_BITS;
  localparam int ROW_WIDTH    = 1 << BIT_SEL_BITS;
  localparam int NAME_CNT_BITS = $clog2(NAME_LENGTH + 1);
  localparam logic [20:0] MEM_WORDS = 21'(1) << ADDRESS_BITS;

  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_EOF  = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_E     = 8'h45;

  typedef enum logic [4:0] {
    PH_HID, PH_NAME, PH_FSTART, PH_FLEN, PH_HCOM, PH_HCR, PH_TID,
    PH_TADDR, PH_TVAL, PH_TCOM, PH_TCR, PH_NEXT, PH_EADDR, PH_DONE
  } phase_e;

  typedef enum logic [4:0] {
    ERR_HID_EOF, ERR_HID_CHAR, ERR_NAME_EOF, ERR_NAME_CHAR,
    ERR_FSTART_EOF, ERR_FSTART_HEX, ERR_FLEN_EOF, ERR_FLEN_HEX,
    ERR_FLEN_ZERO, ERR_FLEN_RANGE, ERR_TID_EOF, ERR_TID_CHAR,
    ERR_TADDR_EOF, ERR_TADDR_HEX, ERR_TADDR_RANGE, ERR_TVAL_EOF,
    ERR_TVAL_HEX, ERR_NEXT_EOF, ERR_NEXT_CHAR, ERR_EADDR_EOF,
    ERR_EADDR_HEX, ERR_EADDR_RANGE
  } err_e;

  // Item waiting for its bitmap row in the second stage
  typedef struct packed {
    logic                    wr;
    logic [15:0]             waddr;
    logic [15:0]             wdata;
    logic                    fin;
    logic [15:0]             exec;
    logic [15:0]             fstart;
    logic                    fail;
    logic [4:0]              code;
    logic [ROW_BITS-1:0]     row;
    logic [BIT_SEL_BITS-1:0] sel;
  } stage_t;

  // Hex value of a character, bit 4 set when not a hex digit
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
    return r;
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  endfunction

  function automatic err_e eof_code(input phase_e p);
    err_e r;
    case (p)
      PH_HID:                    r = ERR_HID_EOF;
      PH_NAME:                   r = ERR_NAME_EOF;
      PH_FSTART:                 r = ERR_FSTART_EOF;
      PH_FLEN:                   r = ERR_FLEN_EOF;
      PH_HCOM, PH_HCR, PH_TID:   r = ERR_TID_EOF;
      PH_TADDR:                  r = ERR_TADDR_EOF;
      PH_TVAL:                   r = ERR_TVAL_EOF;
      PH_TCOM, PH_TCR, PH_NEXT:  r = ERR_NEXT_EOF;
      PH_EADDR:                  r = ERR_EADDR_EOF;
      default:                   r = ERR_HID_EOF;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/object_record_loader.sv
// Object record loader top level: byte parser, written-word bitmap memory
// and two-stage result pipeline. Depends on orl_pkg.

// One stream byte (or command) is taken per cycle while in_stall_o is low.
// Each item gives one result, registered in the parse stage and then in the
// output stage: a parse stage feeds a bitmap-read stage. The written word
// bitmap is a 4096 x 16 synchronous memory. After reset and after every
// begin-new-load command a clearing pass runs, one row per cycle, and
// in_stall_o is high during it. A bitmap write and a read of the same row in
// one cycle are forwarded, so without stalls throughput is one item per cycle.
module object_record_loader import orl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_valid_o,
  output logic [15:0] write_addr_o,
  output logic [15:0] write_data_o,
  output logic        overwrite_warning_o,
  output logic        finished_o,
  output logic [15:0] exec_start_o,
  output logic        exec_start_uninit_o,
  output logic [15:0] footprint_start_o,
  output logic        failed_o,
  output logic [4:0]  error_code_o
);

  // parser state
  phase_e                   phase_q, phase_d;
  logic [2:0]               dcnt_q, dcnt_d;
  logic [15:0]              acc_q, acc_d;
  logic [15:0]              rstart_q, rstart_d;
  logic [16:0]              rend_q, rend_d;
  logic [15:0]              pend_q, pend_d;
  logic                     hinv_q, hinv_d;
  logic                     cr_q, cr_d;
  logic [NAME_CNT_BITS-1:0] ncnt_q, ncnt_d;

  // pipeline
  logic   s1_valid_q;
  stage_t s1_q, s1_d;
  logic   accept, advance;

  // bitmap memory and clearing pass
  logic [ROW_WIDTH-1:0] mem [2**ROW_BITS];
  logic [ROW_WIDTH-1:0] rd_q;
  logic                 clr_q;
  logic [ROW_BITS-1:0]  clr_cnt_q;
  logic                 mem_we;
  logic [ROW_BITS-1:0]  mem_waddr;
  logic [ROW_WIDTH-1:0] mem_wdata;
  logic [15:0]          raddr;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = clr_q || (s1_valid_q && !advance);
  assign accept     = in_valid_i && !in_stall_o;

  // parse one item
  always_comb begin
    phase_e     ph;
    logic [4:0] d;
    logic [2:0] cn;
    logic [15:0] v;
    logic       inv;
    logic       skip;
    phase_d  = phase_q;  dcnt_d = dcnt_q;  acc_d = acc_q;
    rstart_d = rstart_q; rend_d = rend_q;  pend_d = pend_q;
    hinv_d   = hinv_q;   cr_d   = cr_q;    ncnt_d = ncnt_q;
    s1_d     = '0;
    raddr    = pend_q;
    ph   = phase_q;
    skip = 1'b0;
    d    = hex_of(data_byte_i);
    cn   = dcnt_q + 3'd1;
    v    = {acc_q[11:0], d[3:0]};
    inv  = hinv_q | d[4];

    case (cmd_i)
      CMD_LOAD: begin
        phase_d = PH_HID; dcnt_d = '0; acc_d = '0; rstart_d = '0; rend_d = '0;
        pend_d = '0; hinv_d = 1'b0; cr_d = 1'b0; ncnt_d = '0;
      end
      CMD_EOF: begin
        if (phase_q != PH_DONE) begin
          s1_d.fail = 1'b1;
          s1_d.code = eof_code(phase_q);
          phase_d   = PH_DONE;
        end
      end
      CMD_DATA: begin
        if (phase_q != PH_DONE) begin
          // a CR not followed by LF: this byte is the next record id
          if (ph == PH_HCR || ph == PH_TCR) begin
            ph   = (ph == PH_HCR) ? PH_TID : PH_NEXT;
            cr_d = 1'b0;
            skip = (data_byte_i == CH_LF);
          end
          phase_d = ph;
          if (!skip) begin
            case (ph)
              PH_HID: begin
                if (upper(data_byte_i) != CH_H) begin
                  s1_d.fail = 1'b1; s1_d.code = ERR_HID_CHAR; phase_d = PH_DONE;
                end else begin
                  phase_d = PH_NAME; ncnt_d = '0;
                end
              end
              PH_NAME: begin
                if (data_byte_i < CH_SPACE || data_byte_i > CH_TILDE) begin
                  s1_d.fail = 1'b1; s1_d.code = ERR_NAME_CHAR; phase_d = PH_DONE;
                end else begin
                  ncnt_d = ncnt_q + 1'b1;
                  if (ncnt_d >= NAME_CNT_BITS'(NAME_LENGTH)) begin
                    phase_d = PH_FSTART; dcnt_d = '0; hinv_d = 1'b0; acc_d = '0;
                  end
                end
              end
              PH_FSTART, PH_FLEN, PH_TADDR, PH_TVAL, PH_EADDR: begin
                if (cn < 3'd4) begin
                  dcnt_d = cn; acc_d = v; hinv_d = inv;
                end else begin
                  dcnt_d = '0; acc_d = '0; hinv_d = 1'b0;
                  case (ph)
                    PH_FSTART: begin
                      if (inv) begin
                        s1_d.fail = 1'b1; s1_d.code = ERR_FSTART_HEX; phase_d = PH_DONE;
                      end else begin
                        rstart_d = v; phase_d = PH_FLEN;
                      end
                    end
                    PH_FLEN: begin
                      rend_d = {1'b0, rstart_q} + {1'b0, v};
                      if (inv) begin
                        rend_d = rend_q;
                        s1_d.fail = 1'b1; s1_d.code = ERR_FLEN_HEX; phase_d = PH_DONE;
                      end else if (v == '0) begin
                        rend_d = rend_q;
                        s1_d.fail = 1'b1; s1_d.code = ERR_FLEN_ZERO; phase_d = PH_DONE;
                      end else if ({4'b0, rend_d} > MEM_WORDS) begin
                        s1_d.fail = 1'b1; s1_d.code = ERR_FLEN_RANGE; phase_d = PH_DONE;
                      end else begin
                        phase_d = PH_HCOM;
                      end
                    end
                    PH_TADDR: begin
                      if (inv) begin
                        s1_d.fail = 1'b1; s1_d.code = ERR_TADDR_HEX; phase_d = PH_DONE;
                      end else if (v < rstart_q || {1'b0, v} >= rend_q) begin
                        s1_d.fail = 1'b1; s1_d.code = ERR_TADDR_RANGE; phase_d = PH_DONE;
                      end else begin
                        pend_d = v; phase_d = PH_TVAL;
                      end
                    end
                    PH_TVAL: begin
                      if (inv) begin
                        s1_d.fail = 1'b1; s1_d.code = ERR_TVAL_HEX; phase_d = PH_DONE;
                      end else begin
                        s1_d.wr = 1'b1; s1_d.waddr = pend_q; s1_d.wdata = v;
                        phase_d = PH_TCOM;
                      end
                    end
                    default: begin
                      raddr = v;
                      if (inv) begin
                        s1_d.fail = 1'b1; s1_d.code = ERR_EADDR_HEX; phase_d = PH_DONE;
                      end else if (v < rstart_q || {1'b0, v} >= rend_q) begin
                        s1_d.fail = 1'b1; s1_d.code = ERR_EADDR_RANGE; phase_d = PH_DONE;
                      end else begin
                        s1_d.fin = 1'b1; s1_d.exec = v; phase_d = PH_DONE;
                      end
                    end
                  endcase
                end
              end
              PH_HCOM, PH_TCOM: begin
                if (data_byte_i == CH_CR) begin
                  cr_d = 1'b1;
                  phase_d = (ph == PH_HCOM) ? PH_HCR : PH_TCR;
                end else if (data_byte_i == CH_LF) begin
                  phase_d = (ph == PH_HCOM) ? PH_TID : PH_NEXT;
                end
              end
              PH_TID, PH_NEXT: begin
                dcnt_d = '0; hinv_d = 1'b0; acc_d = '0;
                if (upper(data_byte_i) == CH_T) begin
                  phase_d = PH_TADDR;
                end else if (ph == PH_TID) begin
                  s1_d.fail = 1'b1; s1_d.code = ERR_TID_CHAR; phase_d = PH_DONE;
                end else if (upper(data_byte_i) == CH_E) begin
                  phase_d = PH_EADDR;
                end else begin
                  s1_d.fail = 1'b1; s1_d.code = ERR_NEXT_CHAR; phase_d = PH_DONE;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
    s1_d.fstart = rstart_d;
    s1_d.row    = raddr[ADDRESS_BITS-1:BIT_SEL_BITS];
    s1_d.sel    = raddr[BIT_SEL_BITS-1:0];
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HID; dcnt_q <= '0; acc_q <= '0; rstart_q <= '0;
      rend_q <= '0; pend_q <= '0; hinv_q <= 1'b0; cr_q <= 1'b0; ncnt_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d; dcnt_q <= dcnt_d; acc_q <= acc_d; rstart_q <= rstart_d;
      rend_q <= rend_d; pend_q <= pend_d; hinv_q <= hinv_d; cr_q <= cr_d;
      ncnt_q <= ncnt_d;
    end
  end

  // clearing pass after reset and on begin new load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1; clr_cnt_q <= '0;
    end else if (accept && cmd_i == CMD_LOAD) begin
      clr_q <= 1'b1; clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == '1) clr_q <= 1'b0;
    end
  end

  // bitmap write: clearing or setting the bit of a text word
  always_comb begin
    mem_we    = clr_q || (advance && s1_valid_q && s1_q.wr);
    mem_waddr = clr_q ? clr_cnt_q : s1_q.row;
    mem_wdata = clr_q ? '0 : (rd_q | (ROW_WIDTH'(1) << s1_q.sel));
  end

  // bitmap memory, read forwarded from a same-cycle write
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) begin
      if (mem_we && mem_waddr == s1_d.row) rd_q <= mem_wdata;
      else                                 rd_q <= mem[s1_d.row];
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (accept)       s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
      if (advance)      out_valid_o <= s1_valid_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (accept) s1_q <= s1_d;
    if (advance && s1_valid_q) begin
      write_valid_o       <= s1_q.wr;
      write_addr_o        <= s1_q.waddr;
      write_data_o        <= s1_q.wdata;
      overwrite_warning_o <= s1_q.wr && rd_q[s1_q.sel];
      finished_o          <= s1_q.fin;
      exec_start_o        <= s1_q.exec;
      exec_start_uninit_o <= s1_q.fin && !rd_q[s1_q.sel];
      footprint_start_o   <= s1_q.fstart;
      failed_o            <= s1_q.fail;
      error_code_o        <= s1_q.code;
    end
  end

endmodule
